// ===== rtl/core/bpp_pkg.sv =====
// Shared constants and register index codes of the Brovey pansharpening pixel pipeline.
package bpp_pkg;

  localparam int SAMPLE_PORT_W    = 16;
  localparam int WGT_W            = 16;
  localparam int CFG_DATA_W       = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int OUT_W            = 25;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int WEIGHT_FRAC_DEF  = 12;
  localparam int OUT_FRAC_DEF     = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE          = 3'd0,
    CFG_NODATA_ENABLE = 3'd1,
    CFG_NODATA_VALUE  = 3'd2,
    CFG_WEIGHT_0      = 3'd3,
    CFG_WEIGHT_1      = 3'd4,
    CFG_WEIGHT_2      = 3'd5,
    CFG_WEIGHT_3      = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    MODE_RGB    = 1'b0,
    MODE_RGBNIR = 1'b1
  } mode_e;

  localparam logic [CFG_DATA_W-1:0] NODATA_VALUE_RST = 16'd0;
  localparam logic [WGT_W-1:0]      WEIGHT_RGB_RST   = 16'd4096;
  localparam logic [WGT_W-1:0]      WEIGHT_NIR_RST   = 16'd0;

endpackage

// ===== rtl/core/brovey_pansharpen_pixel.sv =====
// Brovey pansharpening pixel pipeline: products, ratio terms, pipelined divider, clip.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-----------------------------------------
//  input    | start, busy (always low)       | red/green/blue/nir/pan_sample_i
//  result   | out_valid_o, one-cycle strobe  | out_red/green/blue_o, out_nodata_o,
//           |                                | out_saturated_o
//  config   | cfg_valid_i, cfg_ready_o       | cfg_index_i, cfg_data_i
//
//  One pixel per cycle in, one result per cycle out, through the registered stages
//  and the restoring divider that retires one quotient bit per stage.
//  rst_ni clears valid bits and loads configuration reset values at once; no clearing pass.
//  The receiver cannot stall, so the pipeline never holds; cfg_ready_o is high only while
//  start is low and no beat is in flight.
module brovey_pansharpen_pixel #(
  parameter int SAMPLE_WIDTH     = bpp_pkg::SAMPLE_WIDTH_DEF,
  parameter int WEIGHT_FRAC_BITS = bpp_pkg::WEIGHT_FRAC_DEF,
  parameter int OUT_FRAC_BITS    = bpp_pkg::OUT_FRAC_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [bpp_pkg::SAMPLE_PORT_W-1:0]        red_sample_i,
  input  logic [bpp_pkg::SAMPLE_PORT_W-1:0]        green_sample_i,
  input  logic [bpp_pkg::SAMPLE_PORT_W-1:0]        blue_sample_i,
  input  logic [bpp_pkg::SAMPLE_PORT_W-1:0]        nir_sample_i,
  input  logic [bpp_pkg::SAMPLE_PORT_W-1:0]        pan_sample_i,
  output logic                                     out_valid_o,
  output logic signed [bpp_pkg::OUT_W-1:0]         out_red_o,
  output logic signed [bpp_pkg::OUT_W-1:0]         out_green_o,
  output logic signed [bpp_pkg::OUT_W-1:0]         out_blue_o,
  output logic                                     out_nodata_o,
  output logic                                     out_saturated_o,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [bpp_pkg::CFG_IDX_W-1:0]            cfg_index_i,
  input  logic [bpp_pkg::CFG_DATA_W-1:0]           cfg_data_i
);

  localparam int WGT_W  = bpp_pkg::WGT_W;
  localparam int OUT_W  = bpp_pkg::OUT_W;
  localparam int CD_W   = bpp_pkg::CFG_DATA_W;
  localparam int CP_W   = 2 * SAMPLE_WIDTH;
  localparam int WC_W   = WGT_W + SAMPLE_WIDTH;
  localparam int POS_W  = SAMPLE_WIDTH + WEIGHT_FRAC_BITS;
  localparam int MAG_W  = (POS_W > WC_W) ? POS_W : WC_W;
  localparam int X_W    = (CP_W > MAG_W) ? CP_W : MAG_W;
  localparam int Y_W    = (WGT_W > SAMPLE_WIDTH) ? WGT_W : SAMPLE_WIDTH;
  localparam int PRD_W  = X_W + Y_W;
  localparam int NUM_W  = PRD_W + OUT_FRAC_BITS;
  localparam int SUM_W  = SAMPLE_WIDTH + 2;
  localparam int DEN0_W = SUM_W + WEIGHT_FRAC_BITS;
  localparam int DEN1_W = WC_W + 2;
  localparam int DEN_W  = (DEN0_W > DEN1_W) ? DEN0_W : DEN1_W;
  localparam int Q_W    = OUT_W;
  localparam int HI_W   = NUM_W - Q_W;
  localparam int CMP_W  = (HI_W > DEN_W) ? HI_W : DEN_W;
  localparam int NDV_W  = CD_W + OUT_FRAC_BITS;
  localparam int EXT_W  = (NDV_W > OUT_W) ? NDV_W : OUT_W;
  localparam int LANES  = 3;

  localparam logic [OUT_W-1:0] POS_LIM = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_LIM = {1'b1, {(OUT_W-1){1'b0}}};

  // configuration
  logic                  mode_q;
  logic                  nodata_en_q;
  logic [CD_W-1:0]       nodata_value_q;
  logic [WGT_W-1:0]      weight_q [4];

  // stage 1: products
  logic                  v1_q;
  logic [SAMPLE_WIDTH-1:0] c1_q  [LANES];
  logic [SAMPLE_WIDTH-1:0] pan1_q;
  logic [CP_W-1:0]       cp1_q [LANES];
  logic [WC_W-1:0]       wc1_q [LANES];
  logic [WC_W-1:0]       wn1_q;
  logic                  nod1_q;
  logic [SAMPLE_WIDTH-1:0] cin [LANES];
  logic [SAMPLE_WIDTH-1:0] pan_in;
  logic [SAMPLE_WIDTH-1:0] nir_in;

  // stage 2: numerator operands and divisor
  logic                  v2_q;
  logic [X_W-1:0]        x2_q [LANES];
  logic [Y_W-1:0]        y2_q [LANES];
  logic [DEN_W-1:0]      den2_q;
  logic                  neg2_q;
  logic                  nod2_q;
  logic [X_W-1:0]        x2_d [LANES];
  logic [Y_W-1:0]        y2_d [LANES];
  logic [DEN_W-1:0]      den2_d;
  logic                  neg2_d;
  logic [SUM_W-1:0]      sum_c;
  logic [MAG_W-1:0]      pos_m;
  logic [MAG_W-1:0]      wn_m;

  // stage 3: full numerator
  logic                  v3_q;
  logic [NUM_W-1:0]      num3_q [LANES];
  logic [DEN_W-1:0]      den3_q;
  logic                  zero3_q;
  logic                  neg3_q;
  logic                  nod3_q;
  logic [PRD_W-1:0]      prd [LANES];

  // divider stages, index 0 holds the range check result
  logic [Q_W:0]          dv_q;
  logic [DEN_W-1:0]      rem_q [Q_W+1][LANES];
  logic [Q_W-1:0]        lo_q  [Q_W+1][LANES];
  logic [Q_W-1:0]        quo_q [Q_W+1][LANES];
  logic [LANES-1:0]      ovf_q [Q_W+1];
  logic [DEN_W-1:0]      den_q [Q_W+1];
  logic [Q_W:0]          zero_q;
  logic [Q_W:0]          neg_q;
  logic [Q_W:0]          nod_q;
  logic [CMP_W-1:0]      hi_c  [LANES];
  logic [CMP_W-1:0]      den_c;
  logic [DEN_W:0]        rx    [Q_W][LANES];
  logic [DEN_W:0]        rdiff [Q_W][LANES];
  logic [LANES-1:0]      ge    [Q_W];
  logic [DEN_W-1:0]      rem_d [Q_W][LANES];

  // output stage
  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_q [LANES];
  logic                  out_nodata_q;
  logic                  out_sat_q;
  logic [OUT_W-1:0]      out_d [LANES];
  logic                  sat_d;
  logic [EXT_W-1:0]      ndv;
  logic [Q_W-1:0]        qf;

  assign busy        = 1'b0;
  assign cfg_ready_o = ~(start | v1_q | v2_q | v3_q | (|dv_q));

  assign cin[0] = red_sample_i[SAMPLE_WIDTH-1:0];
  assign cin[1] = green_sample_i[SAMPLE_WIDTH-1:0];
  assign cin[2] = blue_sample_i[SAMPLE_WIDTH-1:0];
  assign pan_in = pan_sample_i[SAMPLE_WIDTH-1:0];
  assign nir_in = nir_sample_i[SAMPLE_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q         <= bpp_pkg::MODE_RGB;
      nodata_en_q    <= 1'b1;
      nodata_value_q <= bpp_pkg::NODATA_VALUE_RST;
      weight_q[0]    <= bpp_pkg::WEIGHT_RGB_RST;
      weight_q[1]    <= bpp_pkg::WEIGHT_RGB_RST;
      weight_q[2]    <= bpp_pkg::WEIGHT_RGB_RST;
      weight_q[3]    <= bpp_pkg::WEIGHT_NIR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (bpp_pkg::cfg_idx_e'(cfg_index_i))
        bpp_pkg::CFG_MODE:          mode_q         <= cfg_data_i[0];
        bpp_pkg::CFG_NODATA_ENABLE: nodata_en_q    <= cfg_data_i[0];
        bpp_pkg::CFG_NODATA_VALUE:  nodata_value_q <= cfg_data_i;
        bpp_pkg::CFG_WEIGHT_0:      weight_q[0]    <= cfg_data_i;
        bpp_pkg::CFG_WEIGHT_1:      weight_q[1]    <= cfg_data_i;
        bpp_pkg::CFG_WEIGHT_2:      weight_q[2]    <= cfg_data_i;
        bpp_pkg::CFG_WEIGHT_3:      weight_q[3]    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    sum_c = SUM_W'(c1_q[0]) + SUM_W'(c1_q[1]) + SUM_W'(c1_q[2]);
    pos_m = MAG_W'(POS_W'(pan1_q) << WEIGHT_FRAC_BITS);
    wn_m  = MAG_W'(wn1_q);
    if (mode_q == bpp_pkg::MODE_RGBNIR) begin
      neg2_d = wn_m > pos_m;
      for (int k = 0; k < LANES; k++) begin
        x2_d[k] = neg2_d ? X_W'(wn_m - pos_m) : X_W'(pos_m - wn_m);
        y2_d[k] = Y_W'(c1_q[k]);
      end
      den2_d = DEN_W'(wc1_q[0]) + DEN_W'(wc1_q[1]) + DEN_W'(wc1_q[2]);
    end else begin
      neg2_d = 1'b0;
      for (int k = 0; k < LANES; k++) begin
        x2_d[k] = X_W'(cp1_q[k]);
        y2_d[k] = Y_W'(weight_q[k]);
      end
      den2_d = DEN_W'(sum_c) << WEIGHT_FRAC_BITS;
    end
  end

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      prd[k] = PRD_W'(x2_q[k]) * PRD_W'(y2_q[k]);
    end
  end

  // range check: quotient fits Q_W bits only if the high dividend part is below the divisor
  always_comb begin
    den_c = CMP_W'(den3_q);
    for (int k = 0; k < LANES; k++) begin
      hi_c[k] = CMP_W'(num3_q[k][NUM_W-1:Q_W]);
    end
  end

  // one restoring step per stage
  always_comb begin
    for (int j = 0; j < Q_W; j++) begin
      for (int k = 0; k < LANES; k++) begin
        rx[j][k]    = {rem_q[j][k], lo_q[j][k][Q_W-1]};
        rdiff[j][k] = rx[j][k] - {1'b0, den_q[j]};
        ge[j][k]    = rx[j][k] >= {1'b0, den_q[j]};
        rem_d[j][k] = ge[j][k] ? rdiff[j][k][DEN_W-1:0] : rx[j][k][DEN_W-1:0];
      end
    end
  end

  always_comb begin
    ndv   = EXT_W'(NDV_W'(nodata_value_q) << OUT_FRAC_BITS);
    sat_d = 1'b0;
    qf    = '0;
    for (int k = 0; k < LANES; k++) begin
      qf = quo_q[Q_W][k];
      if (nod_q[Q_W]) begin
        if (ndv > EXT_W'(POS_LIM)) begin
          out_d[k] = POS_LIM;
          sat_d    = 1'b1;
        end else begin
          out_d[k] = OUT_W'(ndv);
        end
      end else if (zero_q[Q_W]) begin
        out_d[k] = '0;
      end else if (neg_q[Q_W] && (ovf_q[Q_W][k] || qf != '0)) begin
        if (ovf_q[Q_W][k] || qf > NEG_LIM) begin
          out_d[k] = NEG_LIM;
          sat_d    = 1'b1;
        end else begin
          out_d[k] = ~qf + OUT_W'(1);
        end
      end else begin
        if (ovf_q[Q_W][k] || qf > POS_LIM) begin
          out_d[k] = POS_LIM;
          sat_d    = 1'b1;
        end else begin
          out_d[k] = qf;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      dv_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q        <= start && !busy;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      dv_q        <= {dv_q[Q_W-1:0], v3_q};
      out_valid_q <= dv_q[Q_W];
    end
  end

  // advance payload every cycle; valid bits mark live beats
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < LANES; k++) begin
      c1_q[k]   <= cin[k];
      cp1_q[k]  <= CP_W'(cin[k]) * CP_W'(pan_in);
      wc1_q[k]  <= WC_W'(weight_q[k]) * WC_W'(cin[k]);
      x2_q[k]   <= x2_d[k];
      y2_q[k]   <= y2_d[k];
      num3_q[k] <= NUM_W'(prd[k]) << OUT_FRAC_BITS;
    end
    pan1_q  <= pan_in;
    wn1_q   <= WC_W'(weight_q[3]) * WC_W'(nir_in);
    nod1_q  <= nodata_en_q && (CD_W'(pan_in) == nodata_value_q);

    den2_q  <= den2_d;
    neg2_q  <= neg2_d;
    nod2_q  <= nod1_q;

    den3_q  <= den2_q;
    zero3_q <= den2_q == '0;
    neg3_q  <= neg2_q;
    nod3_q  <= nod2_q;

    for (int k = 0; k < LANES; k++) begin
      ovf_q[0][k] <= hi_c[k] >= den_c;
      rem_q[0][k] <= hi_c[k][DEN_W-1:0];
      lo_q[0][k]  <= num3_q[k][Q_W-1:0];
      quo_q[0][k] <= '0;
    end
    den_q[0]  <= den3_q;
    zero_q[0] <= zero3_q;
    neg_q[0]  <= neg3_q;
    nod_q[0]  <= nod3_q;

    for (int j = 0; j < Q_W; j++) begin
      for (int k = 0; k < LANES; k++) begin
        rem_q[j+1][k] <= rem_d[j][k];
        lo_q[j+1][k]  <= lo_q[j][k] << 1;
        quo_q[j+1][k] <= {quo_q[j][k][Q_W-2:0], ge[j][k]};
      end
      ovf_q[j+1]  <= ovf_q[j];
      den_q[j+1]  <= den_q[j];
      zero_q[j+1] <= zero_q[j];
      neg_q[j+1]  <= neg_q[j];
      nod_q[j+1]  <= nod_q[j];
    end

    for (int k = 0; k < LANES; k++) begin
      out_q[k] <= out_d[k];
    end
    out_nodata_q <= nod_q[Q_W];
    out_sat_q    <= sat_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_red_o       = out_q[0];
  assign out_green_o     = out_q[1];
  assign out_blue_o      = out_q[2];
  assign out_nodata_o    = out_nodata_q;
  assign out_saturated_o = out_sat_q;

endmodule

// ===== test/brovey_pansharpen_pixel_tb.sv =====
// Self-checking testbench of the Brovey pansharpening pixel pipeline.
module brovey_pansharpen_pixel_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_PORT_W = bpp_pkg::SAMPLE_PORT_W;
  localparam int OUT_W = bpp_pkg::OUT_W;
  localparam int CFG_IDX_W = bpp_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = bpp_pkg::CFG_DATA_W;
  localparam int WGT_W = bpp_pkg::WGT_W;
  localparam int W_FRAC = bpp_pkg::WEIGHT_FRAC_DEF;
  localparam int O_FRAC = bpp_pkg::OUT_FRAC_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_PIXELS = 80;
  localparam int DRAIN_CYCLES = OUT_W + 15;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [SAMPLE_PORT_W-1:0] red;
    logic [SAMPLE_PORT_W-1:0] green;
    logic [SAMPLE_PORT_W-1:0] blue;
    logic [SAMPLE_PORT_W-1:0] nir;
    logic [SAMPLE_PORT_W-1:0] pan;
  } pixel_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] red;
    logic signed [OUT_W-1:0] green;
    logic signed [OUT_W-1:0] blue;
    logic                    nodata;
    logic                    saturated;
  } sharp_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    pixel_t                px;
    logic                  typed;
    sharp_t                want;
  } plan_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  pixel_t                pix_drv;
  logic                  out_valid_o;
  logic signed [OUT_W-1:0] out_red_o;
  logic signed [OUT_W-1:0] out_green_o;
  logic signed [OUT_W-1:0] out_blue_o;
  logic                  out_nodata_o;
  logic                  out_saturated_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  use_typed;
  sharp_t                typed_want;

  bpp_pkg::mode_e        cur_mode;
  logic                  nd_en;
  logic [CFG_DATA_W-1:0] nd_value;
  logic [WGT_W-1:0]      weight [4];

  sharp_t                sharp_q [$];
  plan_row_t             plan [$];
  int                    mismatches = 0;
  int                    cycle_count = 0;
  bit                    gaps_on = 1'b1;

  always #10 clk_i = ~clk_i;

  brovey_pansharpen_pixel u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .red_sample_i    (pix_drv.red),
    .green_sample_i  (pix_drv.green),
    .blue_sample_i   (pix_drv.blue),
    .nir_sample_i    (pix_drv.nir),
    .pan_sample_i    (pix_drv.pan),
    .out_valid_o     (out_valid_o),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o),
    .out_nodata_o    (out_nodata_o),
    .out_saturated_o (out_saturated_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  function automatic logic [OUT_W:0] clip25(input logic negv, input logic [63:0] mag);
    if (negv) begin
      if (mag > 64'h1000000) return {1'b1, 25'h1000000};
      return {1'b0, 25'(64'd0 - mag)};
    end
    if (mag > 64'hFFFFFF) return {1'b1, 25'h0FFFFFF};
    return {1'b0, mag[OUT_W-1:0]};
  endfunction

  function automatic sharp_t sharpen(input pixel_t px);
    logic [63:0]      col [3];
    logic [63:0]      scale [3];
    logic [OUT_W-1:0] val [3];
    logic [63:0]      pan, nir, den, num, q, pos, sub;
    logic [OUT_W:0]   sat;
    logic             neg;
    logic             clipped;
    sharp_t           res;
    col[0] = px.red;
    col[1] = px.green;
    col[2] = px.blue;
    nir = px.nir;
    pan = px.pan;
    neg = 1'b0;
    clipped = 1'b0;
    res = '0;
    if (nd_en && px.pan == nd_value) begin
      sat = clip25(1'b0, 64'(nd_value) << O_FRAC);
      res.red = sat[OUT_W-1:0];
      res.green = sat[OUT_W-1:0];
      res.blue = sat[OUT_W-1:0];
      res.nodata = 1'b1;
      res.saturated = sat[OUT_W];
    end else begin
      if (cur_mode == bpp_pkg::MODE_RGB) begin
        den = (col[0] + col[1] + col[2]) << W_FRAC;
        for (int k = 0; k < 3; k++) scale[k] = pan * 64'(weight[k]);
      end else begin
        pos = pan << W_FRAC;
        sub = 64'(weight[3]) * nir;
        if (pos >= sub) begin
          num = pos - sub;
        end else begin
          num = sub - pos;
          neg = 1'b1;
        end
        den = 64'(weight[0]) * col[0] + 64'(weight[1]) * col[1] + 64'(weight[2]) * col[2];
        for (int k = 0; k < 3; k++) scale[k] = num;
      end
      for (int k = 0; k < 3; k++) begin
        q = 64'd0;
        if (den != 0) q = ((col[k] * scale[k]) << O_FRAC) / den;
        sat = clip25(neg && q != 0, q);
        clipped = clipped | sat[OUT_W];
        val[k] = sat[OUT_W-1:0];
      end
      res.red = val[0];
      res.green = val[1];
      res.blue = val[2];
      res.nodata = 1'b0;
      res.saturated = clipped;
    end
    return res;
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      bpp_pkg::CFG_MODE:          cur_mode = bpp_pkg::mode_e'(data[0]);
      bpp_pkg::CFG_NODATA_ENABLE: nd_en = data[0];
      bpp_pkg::CFG_NODATA_VALUE:  nd_value = data;
      bpp_pkg::CFG_WEIGHT_0:      weight[0] = data;
      bpp_pkg::CFG_WEIGHT_1:      weight[1] = data;
      bpp_pkg::CFG_WEIGHT_2:      weight[2] = data;
      bpp_pkg::CFG_WEIGHT_3:      weight[3] = data;
      default: ;
    endcase
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic plan_row_t pix_row(input logic [15:0] r, g, b, n, p);
    plan_row_t row;
    row = '0;
    row.px = '{red: r, green: g, blue: b, nir: n, pan: p};
    return row;
  endfunction

  function automatic plan_row_t chk_row(input logic [15:0] r, g, b, n, p,
                                        input int o_r, o_g, o_b,
                                        input logic nd, sat);
    plan_row_t row;
    row = pix_row(r, g, b, n, p);
    row.typed = 1'b1;
    row.want.red = o_r[OUT_W-1:0];
    row.want.green = o_g[OUT_W-1:0];
    row.want.blue = o_b[OUT_W-1:0];
    row.want.nodata = nd;
    row.want.saturated = sat;
    return row;
  endfunction

  function automatic int idle_len();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_sample();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 15));
      3: return 16'h0001 << $urandom_range(0, 15);
      4: return 16'hFFFF - 16'($urandom_range(0, 15));
      default: return r[15:0];
    endcase
  endfunction

  function automatic logic [15:0] rand_weight();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return bpp_pkg::WEIGHT_RGB_RST;
      3: return 16'($urandom_range(2048, 8192));
      default: return r[15:0];
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.red = rand_sample();
    px.green = rand_sample();
    px.blue = rand_sample();
    px.nir = rand_sample();
    px.pan = rand_sample();
    if ($urandom_range(0, 19) == 0) begin
      px.red = '0;
      px.green = '0;
      px.blue = '0;
    end
    if ($urandom_range(0, 9) == 0) px.pan = nd_value;
    return px;
  endfunction

  function automatic logic [15:0] phase_value(input int ph, input logic [CFG_IDX_W-1:0] idx);
    logic [31:0] r;
    r = $urandom;
    if (ph % 4 == 0) return 16'hFFFF;
    if (ph % 4 == 1) return 16'h0000;
    if (idx >= bpp_pkg::CFG_WEIGHT_0 && idx <= bpp_pkg::CFG_WEIGHT_3) return rand_weight();
    return r[15:0];
  endfunction

  task automatic report_mismatch(input string field, input int got_v, input int want_v);
    $display("MISMATCH %s: got %0d, expected %0d", field, got_v, want_v);
    mismatches++;
  endtask

  task automatic send_pixel(input pixel_t px, input logic typed, input sharp_t want);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    pix_drv <= px;
    use_typed <= typed;
    typed_want <= want;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      cfg_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_cfg(idx, data);
  endtask

  task automatic wait_drain();
    do @(posedge clk_i); while (sharp_q.size() != 0);
  endtask

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk_i) begin : check_results
    sharp_t got;
    sharp_t want;
    if (rst_ni && start && !busy) begin
      if (use_typed) sharp_q.push_back(typed_want);
      else sharp_q.push_back(sharpen(pix_drv));
    end
    if (rst_ni && out_valid_o) begin
      got = '{red: out_red_o, green: out_green_o, blue: out_blue_o,
              nodata: out_nodata_o, saturated: out_saturated_o};
      if (sharp_q.size() == 0) begin
        report_mismatch("out_red with nothing pending", int'(got.red), 0);
      end else begin
        want = sharp_q.pop_front();
        if (got.red !== want.red) report_mismatch("out_red", int'(got.red), int'(want.red));
        if (got.green !== want.green)
          report_mismatch("out_green", int'(got.green), int'(want.green));
        if (got.blue !== want.blue)
          report_mismatch("out_blue", int'(got.blue), int'(want.blue));
        if (got.nodata !== want.nodata)
          report_mismatch("out_nodata", int'(got.nodata), int'(want.nodata));
        if (got.saturated !== want.saturated)
          report_mismatch("out_saturated", int'(got.saturated), int'(want.saturated));
      end
    end
  end

  initial begin : stimulus
    bit in_cfg;
    int off;
    logic [CFG_IDX_W-1:0] idx;
    rst_ni <= 1'b0;
    start <= 1'b0;
    pix_drv <= '0;
    use_typed <= 1'b0;
    typed_want <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= bpp_pkg::CFG_MODE;
    cfg_data_i <= '0;
    cur_mode = bpp_pkg::MODE_RGB;
    nd_en = 1'b1;
    nd_value = bpp_pkg::NODATA_VALUE_RST;
    weight[0] = bpp_pkg::WEIGHT_RGB_RST;
    weight[1] = bpp_pkg::WEIGHT_RGB_RST;
    weight[2] = bpp_pkg::WEIGHT_RGB_RST;
    weight[3] = bpp_pkg::WEIGHT_NIR_RST;
    in_cfg = 1'b0;

    plan.push_back(chk_row(16'd1234, 16'hFFFF, 16'd7, 16'd0, 16'd0, 0, 0, 0, 1'b1, 1'b0));
    plan.push_back(chk_row(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'd100, 0, 0, 0, 1'b0, 1'b0));
    plan.push_back(chk_row(16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 256, 0, 0, 1'b0, 1'b0));
    plan.push_back(chk_row(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF,
                           16776960, 0, 0, 1'b0, 1'b0));
    plan.push_back(chk_row(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF,
                           0, 16776960, 0, 1'b0, 1'b0));
    plan.push_back(chk_row(16'd1, 16'd1, 16'd1, 16'd0, 16'hFFFF,
                           5592320, 5592320, 5592320, 1'b0, 1'b0));
    plan.push_back(pix_row(16'h8000, 16'h00FF, 16'h0F0F, 16'hAAAA, 16'h5555));
    plan.push_back(cfg_row(bpp_pkg::CFG_WEIGHT_0, 16'hFFFF));
    plan.push_back(chk_row(16'hFFFF, 16'd0, 16'd0, 16'd0, 16'hFFFF,
                           16777215, 0, 0, 1'b0, 1'b1));
    plan.push_back(pix_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF));
    plan.push_back(cfg_row(bpp_pkg::CFG_NODATA_ENABLE, 16'd0));
    plan.push_back(pix_row(16'd5, 16'd6, 16'd7, 16'd8, 16'd0));
    plan.push_back(cfg_row(CFG_IDX_SPARE, 16'h1234));
    plan.push_back(pix_row(16'd5, 16'd6, 16'd7, 16'd8, 16'd0));
    plan.push_back(cfg_row(bpp_pkg::CFG_MODE, 16'd1));
    plan.push_back(cfg_row(bpp_pkg::CFG_NODATA_ENABLE, 16'd1));
    plan.push_back(cfg_row(bpp_pkg::CFG_NODATA_VALUE, 16'hFFFF));
    plan.push_back(cfg_row(bpp_pkg::CFG_WEIGHT_0, bpp_pkg::WEIGHT_RGB_RST));
    plan.push_back(cfg_row(bpp_pkg::CFG_WEIGHT_3, 16'hFFFF));
    plan.push_back(chk_row(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0,
                           -16777216, 0, 0, 1'b0, 1'b1));
    plan.push_back(chk_row(16'd1, 16'd2, 16'd3, 16'd4, 16'hFFFF,
                           16776960, 16776960, 16776960, 1'b1, 1'b0));
    plan.push_back(chk_row(16'd0, 16'd0, 16'd0, 16'h1234, 16'h4321, 0, 0, 0, 1'b0, 1'b0));
    plan.push_back(pix_row(16'd300, 16'd200, 16'd100, 16'd100, 16'd1000));
    plan.push_back(pix_row(16'h00FF, 16'hFF00, 16'h0001, 16'hFFFF, 16'hFFFE));
    plan.push_back(cfg_row(bpp_pkg::CFG_WEIGHT_1, 16'd0));
    plan.push_back(cfg_row(bpp_pkg::CFG_WEIGHT_2, 16'd0));
    plan.push_back(cfg_row(bpp_pkg::CFG_WEIGHT_3, 16'd0));
    plan.push_back(chk_row(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFE,
                           0, 0, 0, 1'b0, 1'b0));
    plan.push_back(pix_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFE));
    plan.push_back(cfg_row(bpp_pkg::CFG_MODE, 16'hFFFE));
    plan.push_back(pix_row(16'd10, 16'd20, 16'd30, 16'd0, 16'h1000));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!in_cfg) begin
          start <= 1'b0;
          wait_drain();
          in_cfg = 1'b1;
        end
        cfg_write(plan[i].idx, plan[i].data);
      end else begin
        if (in_cfg) begin
          cfg_valid_i <= 1'b0;
          in_cfg = 1'b0;
        end
        send_pixel(plan[i].px, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      start <= 1'b0;
      wait_drain();
      gaps_on = ($urandom_range(0, 3) != 0);
      off = $urandom_range(0, 7);
      for (int j = 0; j < 8; j++) begin
        idx = CFG_IDX_W'((j + off) % 8);
        cfg_write(idx, phase_value(ph, idx));
      end
      cfg_valid_i <= 1'b0;
      for (int n = 0; n < PHASE_PIXELS; n++) begin
        if ($urandom_range(0, 199) == 0) begin
          start <= 1'b0;
          wait_drain();
        end
        send_pixel(rand_pixel(), 1'b0, '0);
      end
    end

    start <= 1'b0;
    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
